// File: rtl/pinhole_camera_projection_defines.svh
// Assertion macros for the pinhole camera projection block
`ifndef PINHOLE_CAMERA_PROJECTION_DEFINES_SVH
`define PINHOLE_CAMERA_PROJECTION_DEFINES_SVH

// generic property, sampled on clk_i, off during reset
`define PCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// signal unchanged in the cycle after cond
`define PCP_ASSERT_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) cond |=> $stable(sig)) \
    else $error(msg);

`endif

// File: rtl/pcp_pkg.sv
// Shared constants, types and helpers of the pinhole camera projection block
package pcp_pkg;

  localparam int COEF_BITS = 21;
  localparam int PT_W      = 32;
  localparam int ROT_FRAC  = 18;
  localparam int TK_FRAC   = 8;
  localparam int PT_FRAC   = 16;
  localparam int ALIGN_SH  = ROT_FRAC + PT_FRAC - TK_FRAC;
  localparam int REG_W     = 63;
  localparam int NUM_REGS  = 7;
  localparam int IDX_W     = 3;
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;

  localparam int PROD1_W   = COEF_BITS + PT_W;
  localparam int ACC1_W    = PROD1_W + 3;
  localparam int CAM_W     = ACC1_W - ROT_FRAC;
  localparam int PROD2_W   = COEF_BITS + CAM_W;
  localparam int K_W       = PROD2_W + 2;
  localparam int MAG_W     = K_W;
  localparam int Q_W       = PT_W - 1;
  localparam int INT_BITS  = Q_W - PT_FRAC;
  localparam int DIV_STEPS = Q_W;

  localparam logic [IDX_W-1:0] REG_ROT0  = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROT1  = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROT2  = 3'd2;
  localparam logic [IDX_W-1:0] REG_TRANS = 3'd3;
  localparam logic [IDX_W-1:0] REG_K0    = 3'd4;
  localparam logic [IDX_W-1:0] REG_K1    = 3'd5;
  localparam logic [IDX_W-1:0] REG_K2    = 3'd6;

  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef logic [REG_W-1:0]            reg_t;
  typedef logic signed [PT_W-1:0]      pt_t;
  typedef logic signed [CAM_W-1:0]     cam_t;
  typedef logic signed [K_W-1:0]       kacc_t;
  typedef logic [MAG_W-1:0]            mag_t;
  typedef logic [Q_W-1:0]              quot_t;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic sat_x;
    logic sat_y;
    logic bad;
    pt_t  depth;
  } div_meta_t;

  function automatic coef_t get_coef(reg_t r, int unsigned j);
    get_coef = r[j*COEF_BITS +: COEF_BITS];
  endfunction

  function automatic pt_t sat32(kacc_t v);
    logic [K_W-PT_W:0] top;
    top = v[K_W-1:PT_W-1];
    if ((&top) || !(|top)) begin
      sat32 = v[PT_W-1:0];
    end else if (v[K_W-1]) begin
      sat32 = {1'b1, {(PT_W-1){1'b0}}};
    end else begin
      sat32 = {1'b0, {(PT_W-1){1'b1}}};
    end
  endfunction

endpackage

// File: rtl/pcp_extrinsic.sv
// Rotation and translation stages: camera point from world point
module pcp_extrinsic (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  pcp_pkg::pt_t   world_x_i,
  input  pcp_pkg::pt_t   world_y_i,
  input  pcp_pkg::pt_t   world_z_i,
  input  pcp_pkg::reg_t  rot0_i,
  input  pcp_pkg::reg_t  rot1_i,
  input  pcp_pkg::reg_t  rot2_i,
  input  pcp_pkg::reg_t  trans_i,
  output logic           valid_o,
  output pcp_pkg::cam_t  cam_o [3]
);
  import pcp_pkg::*;

  typedef logic signed [PROD1_W-1:0] prod1_t;
  typedef logic signed [ACC1_W-1:0]  acc1_t;

  pt_t    pt [3];
  reg_t   rot [3];
  prod1_t prod_q [3][3];
  coef_t  tr_q [3];
  acc1_t  acc [3];
  acc1_t  sh [3];
  cam_t   cam_q [3];
  logic   v1_q, v2_q;

  assign pt[0]  = world_x_i;
  assign pt[1]  = world_y_i;
  assign pt[2]  = world_z_i;
  assign rot[0] = rot0_i;
  assign rot[1] = rot1_i;
  assign rot[2] = rot2_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= PROD1_W'(get_coef(rot[i], j)) * PROD1_W'(pt[j]);
        end
        tr_q[i] <= get_coef(trans_i, i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = ACC1_W'(prod_q[i][0]) + ACC1_W'(prod_q[i][1]) + ACC1_W'(prod_q[i][2])
             + (ACC1_W'(tr_q[i]) <<< ALIGN_SH) + (ACC1_W'(1) <<< (ROT_FRAC - 1));
      sh[i]  = acc[i] >>> ROT_FRAC;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        cam_q[i] <= sh[i][CAM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign cam_o   = cam_q;

endmodule

// File: rtl/pcp_intrinsic.sv
// Intrinsic matrix stages: homogeneous image sums from camera point
module pcp_intrinsic (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  pcp_pkg::cam_t  cam_i [3],
  input  pcp_pkg::reg_t  k0_i,
  input  pcp_pkg::reg_t  k1_i,
  input  pcp_pkg::reg_t  k2_i,
  output logic           valid_o,
  output pcp_pkg::kacc_t k_o [3]
);
  import pcp_pkg::*;

  typedef logic signed [PROD2_W-1:0] prod2_t;

  reg_t   kr [3];
  prod2_t prod_q [3][3];
  kacc_t  k_q [3];
  logic   v1_q, v2_q;

  assign kr[0] = k0_i;
  assign kr[1] = k1_i;
  assign kr[2] = k2_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= PROD2_W'(get_coef(kr[i], j)) * PROD2_W'(cam_i[j]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        k_q[i] <= K_W'(prod_q[i][0]) + K_W'(prod_q[i][1]) + K_W'(prod_q[i][2]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign k_o     = k_q;

endmodule

// File: rtl/pcp_divider.sv
// Pipelined restoring divider, one quotient bit per stage, x and y in parallel
module pcp_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  pcp_pkg::kacc_t     k_i [3],
  output logic               valid_o,
  output pcp_pkg::quot_t     qx_o,
  output pcp_pkg::quot_t     qy_o,
  output pcp_pkg::div_meta_t meta_o
);
  import pcp_pkg::*;

  typedef logic [INT_BITS-1:0] low_t;

  kacc_t     dep_r;
  mag_t      nx, ny, den;
  div_meta_t meta_d;

  mag_t      rx_q [DIV_STEPS+1];
  mag_t      ry_q [DIV_STEPS+1];
  mag_t      d_q  [DIV_STEPS+1];
  low_t      lx_q [DIV_STEPS+1];
  low_t      ly_q [DIV_STEPS+1];
  quot_t     qx_q [DIV_STEPS+1];
  quot_t     qy_q [DIV_STEPS+1];
  div_meta_t meta_q [DIV_STEPS+1];
  logic [DIV_STEPS:0] v_q;

  always_comb begin
    dep_r        = (k_i[2] + (K_W'(1) <<< (TK_FRAC - 1))) >>> TK_FRAC;
    meta_d.bad   = (k_i[2] <= 0);
    meta_d.depth = sat32(dep_r);
    meta_d.neg_x = k_i[0][K_W-1];
    meta_d.neg_y = k_i[1][K_W-1];
    nx           = meta_d.neg_x ? mag_t'(-k_i[0]) : mag_t'(k_i[0]);
    ny           = meta_d.neg_y ? mag_t'(-k_i[1]) : mag_t'(k_i[1]);
    den          = mag_t'(k_i[2]);
    meta_d.sat_x = (nx >> INT_BITS) >= den;
    meta_d.sat_y = (ny >> INT_BITS) >= den;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q[0]   <= nx >> INT_BITS;
      ry_q[0]   <= ny >> INT_BITS;
      d_q[0]    <= den;
      lx_q[0]   <= nx[INT_BITS-1:0];
      ly_q[0]   <= ny[INT_BITS-1:0];
      qx_q[0]   <= '0;
      qy_q[0]   <= '0;
      meta_q[0] <= meta_d;
    end
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    localparam int B = Q_W - 1 - s;
    logic             bx, by, gex, gey;
    logic [MAG_W:0]   tx, ty, dd, subx, suby;

    if (B >= PT_FRAC) begin : g_int
      assign bx = lx_q[s][B-PT_FRAC];
      assign by = ly_q[s][B-PT_FRAC];
    end else begin : g_frac
      assign bx = 1'b0;
      assign by = 1'b0;
    end

    assign tx   = {rx_q[s], bx};
    assign ty   = {ry_q[s], by};
    assign dd   = {1'b0, d_q[s]};
    assign gex  = tx >= dd;
    assign gey  = ty >= dd;
    assign subx = tx - dd;
    assign suby = ty - dd;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[s+1]   <= gex ? subx[MAG_W-1:0] : tx[MAG_W-1:0];
        ry_q[s+1]   <= gey ? suby[MAG_W-1:0] : ty[MAG_W-1:0];
        d_q[s+1]    <= d_q[s];
        lx_q[s+1]   <= lx_q[s];
        ly_q[s+1]   <= ly_q[s];
        qx_q[s+1]   <= {qx_q[s][Q_W-2:0], gex};
        qy_q[s+1]   <= {qy_q[s][Q_W-2:0], gey};
        meta_q[s+1] <= meta_q[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DIV_STEPS-1:0], valid_i};
    end
  end

  assign valid_o = v_q[DIV_STEPS];
  assign qx_o    = qx_q[DIV_STEPS];
  assign qy_o    = qy_q[DIV_STEPS];
  assign meta_o  = meta_q[DIV_STEPS];

endmodule

// File: rtl/pinhole_camera_projection.sv
// Pinhole camera projection top level: config registers, pipeline, output register
// Projects one world point (Q16.16) per clock: camera = R*X + t, then the 3x3
// intrinsic matrix, then pixel = row sum / depth. A new transaction is taken every
// cycle while the output side keeps up. The pipeline has two stages for the
// rotation/translation, two for the intrinsic products, one divider setup stage,
// 31 restoring divider stages (one quotient bit each), and the output register.
// The whole pipeline stalls together when a result is held at the output.
// Registers are 63-bit values at byte address 8*i (R rows 0..2, t, K rows 0..2),
// written by the user only while the block is idle; the block does not enforce it.
module pinhole_camera_projection (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [31:0]            world_x_i,
  input  logic signed [31:0]            world_y_i,
  input  logic signed [31:0]            world_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [31:0]            pixel_x_o,
  output logic signed [31:0]            pixel_y_o,
  output logic signed [31:0]            cam_depth_o,
  output logic                          invalid_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcp_pkg::ADDR_W-1:0]    paddr,
  input  logic [pcp_pkg::DATA_W-1:0]    pwdata,
  output logic [pcp_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import pcp_pkg::*;

  reg_t       regs_q [NUM_REGS];
  logic [IDX_W-1:0] idx;
  logic       adv;
  logic       ext_valid, int_valid, div_valid;
  cam_t       cam [3];
  kacc_t      kv [3];
  quot_t      qx, qy;
  div_meta_t  meta;
  pt_t        px_d, py_d;
  logic       out_valid_q;
  pt_t        px_q, py_q, dep_q;
  logic       bad_q;

  assign idx    = paddr[ADDR_W-1:ADDR_W-IDX_W];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= '0;
      end
    end else if (psel && penable && pwrite && (idx < IDX_W'(NUM_REGS))) begin
      regs_q[idx] <= pwdata[REG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (idx < IDX_W'(NUM_REGS)) begin
      prdata = DATA_W'(regs_q[idx]);
    end
  end

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  pcp_extrinsic u_ext (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (in_valid_i),
    .world_x_i (world_x_i),
    .world_y_i (world_y_i),
    .world_z_i (world_z_i),
    .rot0_i    (regs_q[REG_ROT0]),
    .rot1_i    (regs_q[REG_ROT1]),
    .rot2_i    (regs_q[REG_ROT2]),
    .trans_i   (regs_q[REG_TRANS]),
    .valid_o   (ext_valid),
    .cam_o     (cam)
  );

  pcp_intrinsic u_int (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (ext_valid),
    .cam_i   (cam),
    .k0_i    (regs_q[REG_K0]),
    .k1_i    (regs_q[REG_K1]),
    .k2_i    (regs_q[REG_K2]),
    .valid_o (int_valid),
    .k_o     (kv)
  );

  pcp_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (int_valid),
    .k_i     (kv),
    .valid_o (div_valid),
    .qx_o    (qx),
    .qy_o    (qy),
    .meta_o  (meta)
  );

  always_comb begin
    if (meta.bad) begin
      px_d = '0;
    end else if (meta.sat_x) begin
      px_d = meta.neg_x ? {1'b1, {(PT_W-1){1'b0}}} : {1'b0, {(PT_W-1){1'b1}}};
    end else begin
      px_d = meta.neg_x ? -PT_W'(qx) : PT_W'(qx);
    end
    if (meta.bad) begin
      py_d = '0;
    end else if (meta.sat_y) begin
      py_d = meta.neg_y ? {1'b1, {(PT_W-1){1'b0}}} : {1'b0, {(PT_W-1){1'b1}}};
    end else begin
      py_d = meta.neg_y ? -PT_W'(qy) : PT_W'(qy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q  <= px_d;
      py_q  <= py_d;
      dep_q <= meta.depth;
      bad_q <= meta.bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = px_q;
  assign pixel_y_o   = py_q;
  assign cam_depth_o = dep_q;
  assign invalid_o   = bad_q;

endmodule

// File: rtl/pcp_checker.sv
// Port-level checker for the pinhole camera projection block, with its bind
`include "pinhole_camera_projection_defines.svh"

module pcp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] pixel_x_o,
  input logic signed [31:0] pixel_y_o,
  input logic signed [31:0] cam_depth_o,
  input logic               invalid_o
);

  `PCP_ASSERT(a_bad_zero, out_valid_o && invalid_o |-> (pixel_x_o == 0 && pixel_y_o == 0), "pixels not zero on bad depth")
  `PCP_ASSERT(a_dep_sign, out_valid_o && !invalid_o |-> !cam_depth_o[31], "negative depth marked valid")
  `PCP_ASSERT(a_ready, !out_valid_o |-> in_ready_o, "input stalled with empty output")
  `PCP_ASSERT_HOLD(a_out_hold, out_valid_o && !out_ready_i, {out_valid_o, pixel_x_o, pixel_y_o, cam_depth_o, invalid_o}, "stalled transaction changed")

endmodule

bind pinhole_camera_projection pcp_checker u_pcp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .pixel_x_o   (pixel_x_o),
  .pixel_y_o   (pixel_y_o),
  .cam_depth_o (cam_depth_o),
  .invalid_o   (invalid_o)
);

// File: test/pinhole_camera_projection_tb.sv
// Testbench for pinhole_camera_projection: directed and random points checked against a predictor
module pinhole_camera_projection_tb;
  import pcp_pkg::*;

  typedef struct {
    pt_t  pixel_x;
    pt_t  pixel_y;
    pt_t  depth;
    logic invalid;
  } projection_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 45;
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  pt_t world_x_i = '0;
  pt_t world_y_i = '0;
  pt_t world_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  pt_t pixel_x_o, pixel_y_o, cam_depth_o;
  logic invalid_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  reg_t        camera_regs [NUM_REGS];
  projection_t pending_projections [$];
  int          fail_count = 0;
  bit          no_idle = 1'b0;
  int          hold_request = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  pinhole_camera_projection uut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint coef_of(reg_t r, int j);
    coef_t c;
    c = r[j*COEF_BITS +: COEF_BITS];
    return longint'(c);
  endfunction

  function automatic longint round_up(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // num * 2^16 / den, toward zero, saturated; den > 0
  function automatic longint scaled_quotient(longint num, longint den);
    logic neg;
    longint unsigned n, d, q, r, mag;
    neg = num < 0;
    n = neg ? -num : num;
    d = den;
    q = n / d;
    r = n % d;
    if (q >= (64'd1 << (31 - PT_FRAC)))
      return neg ? -64'sd2147483648 : 64'sd2147483647;
    mag = q;
    for (int i = 0; i < PT_FRAC; i++) begin
      r = r << 1;
      mag = mag << 1;
      if (r >= d) begin
        r = r - d;
        mag = mag | 64'd1;
      end
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic projection_t project_point(pt_t x, pt_t y, pt_t z);
    projection_t res;
    longint pnt [3];
    longint cam [3];
    longint hom [3];
    longint acc;
    pnt[0] = x;
    pnt[1] = y;
    pnt[2] = z;
    for (int i = 0; i < 3; i++) begin
      acc = coef_of(camera_regs[REG_TRANS], i) * (64'sd1 <<< ALIGN_SH);
      for (int j = 0; j < 3; j++) acc += coef_of(camera_regs[i], j) * pnt[j];
      cam[i] = round_up(acc, ROT_FRAC);
    end
    for (int i = 0; i < 3; i++) begin
      hom[i] = 0;
      for (int j = 0; j < 3; j++) hom[i] += coef_of(camera_regs[REG_K0 + i], j) * cam[j];
    end
    res.depth = pt_t'(clamp32(round_up(hom[2], TK_FRAC)));
    res.invalid = hom[2] <= 0;
    res.pixel_x = res.invalid ? '0 : pt_t'(scaled_quotient(hom[0], hom[2]));
    res.pixel_y = res.invalid ? '0 : pt_t'(scaled_quotient(hom[1], hom[2]));
    return res;
  endfunction

  function automatic reg_t pack3(longint c0, longint c1, longint c2);
    coef_t a, b, c;
    a = coef_t'(c0);
    b = coef_t'(c1);
    c = coef_t'(c2);
    return reg_t'({c, b, a});
  endfunction

  function automatic pt_t random_coord();
    case ($urandom_range(3))
      0: return pt_t'($urandom);
      1: return pt_t'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      default: return pt_t'($urandom_range(0, 32'h03FF_FFFF)) - 32'sh0100_0000;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= no_idle || ($urandom_range(99) >= 24);
    end
  end

  always @(posedge clk_i) begin
    projection_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_projections.size() == 0) begin
        $error("unexpected transaction: pixel_x %0d pixel_y %0d", pixel_x_o, pixel_y_o);
        fail_count++;
      end else begin
        exp_res = pending_projections.pop_front();
        if (pixel_x_o !== exp_res.pixel_x) begin
          $error("pixel_x expected %0d actual %0d", exp_res.pixel_x, pixel_x_o);
          fail_count++;
        end
        if (pixel_y_o !== exp_res.pixel_y) begin
          $error("pixel_y expected %0d actual %0d", exp_res.pixel_y, pixel_y_o);
          fail_count++;
        end
        if (cam_depth_o !== exp_res.depth) begin
          $error("cam_depth expected %0d actual %0d", exp_res.depth, cam_depth_o);
          fail_count++;
        end
        if (invalid_o !== exp_res.invalid) begin
          $error("invalid expected %0b actual %0b", exp_res.invalid, invalid_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel || !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, reg_t value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 8);
    pwdata <= DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx < NUM_REGS) camera_regs[idx] = value;
  endtask

  task automatic send_point(pt_t x, pt_t y, pt_t z);
    while (!no_idle && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    world_x_i <= x;
    world_y_i <= y;
    world_z_i <= z;
    do @(posedge clk_i); while (!in_ready_o);
    pending_projections = {pending_projections, project_point(x, y, z)};
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_projections.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_camera(reg_t r0, reg_t r1, reg_t r2, reg_t t, reg_t k0, reg_t k1,
                             reg_t k2);
    write_reg(REG_ROT0, r0);
    write_reg(REG_ROT1, r1);
    write_reg(REG_ROT2, r2);
    write_reg(REG_TRANS, t);
    write_reg(REG_K0, k0);
    write_reg(REG_K1, k1);
    write_reg(REG_K2, k2);
  endtask

  task automatic load_pinhole();
    load_camera(pack3(1 << 18, 0, 0), pack3(0, 1 << 18, 0), pack3(0, 0, 1 << 18),
                pack3(0, 0, 5 << 8), pack3(500 << 8, 0, 320 << 8),
                pack3(0, 500 << 8, 240 << 8), pack3(0, 0, 1 << 8));
  endtask

  task automatic send_random(int count);
    repeat (count) send_point(random_coord(), random_coord(), random_coord());
  endtask

  task automatic test_reset_registers();
    send_point(32'sh0001_0000, -32'sh0002_0000, 32'sh7FFF_FFFF);
    send_point('0, '0, '0);
    drain();
  endtask

  task automatic test_directed_points();
    pt_t corner [4];
    corner[0] = 32'sh7FFF_FFFF;
    corner[1] = 32'sh8000_0000;
    corner[2] = '0;
    corner[3] = -32'sd1;
    load_pinhole();
    write_reg(REG_UNUSED, '1);
    foreach (corner[i]) send_point(corner[i], corner[3 - i], corner[(i + 1) % 4]);
    send_point(32'sh0001_0000, 32'sh0001_0000, -32'sh0005_0000);
    send_point(32'sh0001_0000, 32'sh0001_0000, -32'sh0006_0000);
    send_point(32'sh0001_0000, -32'sh0001_0000, -32'sh0004_FFFF);
    send_point(32'sh7FFF_0000, 32'sh8000_0000, -32'sh0004_FFFF);
    send_point(32'sh0003_8000, -32'sh0002_4000, 32'sh0001_0000);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    drain();
  endtask

  task automatic test_tiny_depth();
    load_camera(pack3(1 << 18, 0, 0), pack3(0, 1 << 18, 0), pack3(0, 0, 1 << 18), '0,
                pack3(1 << 8, 0, 0), pack3(0, -(1 << 8), 0), pack3(0, 0, 1));
    send_point(32'sh0001_0000, 32'sh0002_0000, 32'sd1);
    send_point(-32'sh0001_0000, 32'sh7FFF_FFFF, 32'sd1);
    send_point(32'sd5, 32'sd3, 32'sd127);
    send_point(32'sd5, 32'sd3, 32'sd128);
    send_point(32'sd5, 32'sd3, -32'sd1);
    drain();
  endtask

  task automatic test_extreme_coefficients();
    reg_t hi, lo;
    hi = pack3((1 << 20) - 1, (1 << 20) - 1, (1 << 20) - 1);
    lo = pack3(-(1 << 20), -(1 << 20), -(1 << 20));
    load_camera(hi, hi, hi, hi, hi, hi, hi);
    send_random(30);
    drain();
    load_camera(lo, lo, lo, lo, lo, lo, lo);
    send_random(30);
    drain();
    load_camera(hi, lo, hi, lo, hi, lo, '1);
    send_random(30);
    drain();
  endtask

  task automatic test_random_cameras();
    for (int k = 0; k < 5; k++) begin
      if (k == 0) begin
        load_pinhole();
      end else if (k == 1) begin
        load_camera(pack3(0, -(1 << 18), 0), pack3(1 << 18, 0, 0), pack3(0, 0, 1 << 18),
                    pack3(-(3 << 8), 2 << 8, 10 << 8), pack3(800 << 8, 64, 640 << 8),
                    pack3(0, 800 << 8, 360 << 8), pack3(0, 0, 1 << 8));
      end else begin
        load_camera(reg_t'({$urandom, $urandom}), reg_t'({$urandom, $urandom}),
                    reg_t'({$urandom, $urandom}), reg_t'({$urandom, $urandom}),
                    reg_t'({$urandom, $urandom}), reg_t'({$urandom, $urandom}),
                    reg_t'({$urandom, $urandom}));
      end
      no_idle = (k == 2);
      send_random(110);
      drain();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    load_pinhole();
    hold_request = 300;
    no_idle = 1'b1;
    send_random(90);
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    for (int i = 0; i < NUM_REGS; i++) camera_regs[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_registers();
    test_directed_points();
    test_tiny_depth();
    test_extreme_coefficients();
    test_random_cameras();
    test_backpressure();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/pcp_pkg.sv
rtl/pcp_extrinsic.sv
rtl/pcp_intrinsic.sv
rtl/pcp_divider.sv
rtl/pinhole_camera_projection.sv
rtl/pcp_checker.sv
test/pinhole_camera_projection_tb.sv
